>>> hdl/irc_pkg.sv
// Shared types and constants for the IRC message line parser.
// Holds the word structs, the grammar state codes, byte role codes and byte values.
// No dependencies.
package irc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_end;
  } in_word_t;

  typedef struct packed {
    logic [2:0] byte_role;
    logic [3:0] param_index;
    logic       field_start;
    logic       verdict_valid;
    logic       accepted;
  } out_word_t;

  // Grammar state codes.
  localparam logic [3:0] ST_START     = 4'd0;
  localparam logic [3:0] ST_PFX_FIRST = 4'd1;
  localparam logic [3:0] ST_PFX       = 4'd2;
  localparam logic [3:0] ST_PFX_SP    = 4'd3;
  localparam logic [3:0] ST_CMD_ALPHA = 4'd4;
  localparam logic [3:0] ST_CMD_D1    = 4'd5;
  localparam logic [3:0] ST_CMD_D2    = 4'd6;
  localparam logic [3:0] ST_CMD_D3    = 4'd7;
  localparam logic [3:0] ST_PAR_SP    = 4'd8;
  localparam logic [3:0] ST_TRAIL_1ST = 4'd9;
  localparam logic [3:0] ST_MID       = 4'd10;
  localparam logic [3:0] ST_TRAIL     = 4'd11;
  localparam logic [3:0] ST_DONE      = 4'd12;
  localparam logic [3:0] ST_ERR       = 4'd13;

  // Byte role codes.
  localparam logic [2:0] ROLE_SEP = 3'd0;
  localparam logic [2:0] ROLE_PFX = 3'd1;
  localparam logic [2:0] ROLE_CMD = 3'd2;
  localparam logic [2:0] ROLE_MID = 3'd3;
  localparam logic [2:0] ROLE_TRL = 3'd4;
  localparam logic [2:0] ROLE_CR  = 3'd5;
  localparam logic [2:0] ROLE_BAD = 3'd6;

  // Byte values.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

endpackage

>>> hdl/irc_step.sv
// Single-byte grammar step for the IRC message line parser.
// Classifies one byte against the current grammar state and gives the next state.
// Depends on irc_pkg.
module irc_step import irc_pkg::*; #(
  parameter int MAX_PARAMS = 15
) (
  input  in_word_t   word,
  input  logic [3:0] state,
  input  logic [3:0] pcnt,
  input  logic       skip,
  output out_word_t  res,
  output logic [3:0] state_nxt,
  output logic [3:0] pcnt_nxt,
  output logic       skip_nxt
);

  localparam logic [3:0] PcMax = 4'(MAX_PARAMS);

  logic [7:0] c;
  logic       is_plain;
  logic       is_alpha;
  logic       is_digit;
  logic [3:0] ns;
  logic [3:0] pc;

  assign c        = word.data_byte;
  assign is_plain = (c != CH_NUL) && (c != CH_LF) && (c != CH_CR) &&
                    (c != CH_SPACE) && (c != CH_COLON);
  assign is_alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);

  always_comb begin
    res       = '0;
    ns        = ST_ERR;
    pc        = pcnt;
    state_nxt = state;
    pcnt_nxt  = pcnt;
    skip_nxt  = skip;

    if (skip) begin
      // Bytes after a NUL are ignored until the end of the line.
      if (word.line_end) begin
        state_nxt = ST_START;
        pcnt_nxt  = '0;
        skip_nxt  = 1'b0;
      end
    end else if (c == CH_NUL) begin
      res.verdict_valid = 1'b1;
      res.accepted      = (state == ST_DONE);
      if (word.line_end) begin
        state_nxt = ST_START;
        pcnt_nxt  = '0;
      end else begin
        skip_nxt = 1'b1;
      end
    end else begin
      res.byte_role = ROLE_SEP;
      unique case (state)
        ST_START: begin
          if (c == CH_COLON) begin
            ns = ST_PFX_FIRST;
          end else if (is_alpha) begin
            ns = ST_CMD_ALPHA; res.byte_role = ROLE_CMD; res.field_start = 1'b1;
          end else if (is_digit) begin
            ns = ST_CMD_D1; res.byte_role = ROLE_CMD; res.field_start = 1'b1;
          end
        end
        ST_PFX_FIRST: begin
          if (is_plain) begin
            ns = ST_PFX; res.byte_role = ROLE_PFX; res.field_start = 1'b1;
          end
        end
        ST_PFX: begin
          if (is_plain) begin
            ns = ST_PFX; res.byte_role = ROLE_PFX;
          end else if (c == CH_SPACE) begin
            ns = ST_PFX_SP;
          end
        end
        ST_PFX_SP: begin
          if (c == CH_SPACE) begin
            ns = ST_PFX_SP;
          end else if (is_alpha) begin
            ns = ST_CMD_ALPHA; res.byte_role = ROLE_CMD; res.field_start = 1'b1;
          end else if (is_digit) begin
            ns = ST_CMD_D1; res.byte_role = ROLE_CMD; res.field_start = 1'b1;
          end
        end
        ST_CMD_ALPHA: begin
          if (is_alpha) begin
            ns = ST_CMD_ALPHA; res.byte_role = ROLE_CMD;
          end else if (c == CH_SPACE) begin
            ns = ST_PAR_SP;
          end
        end
        ST_CMD_D1: begin
          if (is_digit) begin
            ns = ST_CMD_D2; res.byte_role = ROLE_CMD;
          end
        end
        ST_CMD_D2: begin
          if (is_digit) begin
            ns = ST_CMD_D3; res.byte_role = ROLE_CMD;
          end
        end
        ST_CMD_D3: begin
          if (c == CH_SPACE) begin
            ns = ST_PAR_SP;
          end
        end
        ST_PAR_SP: begin
          if (c == CH_SPACE) begin
            ns = ST_PAR_SP;
          end else if (c == CH_COLON) begin
            ns = ST_TRAIL_1ST;
          end else if (c == CH_CR) begin
            ns = ST_DONE; res.byte_role = ROLE_CR;
          end else if (is_plain) begin
            ns = ST_MID; res.byte_role = ROLE_MID; res.param_index = pcnt;
            res.field_start = 1'b1;
          end
        end
        ST_TRAIL_1ST: begin
          if ((c != CH_LF) && (c != CH_CR)) begin
            ns = ST_TRAIL; res.byte_role = ROLE_TRL; res.param_index = pcnt;
            res.field_start = 1'b1;
          end
        end
        ST_MID: begin
          if (is_plain || (c == CH_COLON)) begin
            ns = ST_MID; res.byte_role = ROLE_MID; res.param_index = pcnt;
          end else if (c == CH_SPACE) begin
            ns = ST_PAR_SP;
            // The parameter count sticks at its limit.
            if (pcnt < PcMax) begin
              pc = pcnt + 4'd1;
            end
          end
        end
        ST_TRAIL: begin
          if (c == CH_CR) begin
            ns = ST_DONE; res.byte_role = ROLE_CR;
          end else if (c != CH_LF) begin
            ns = ST_TRAIL; res.byte_role = ROLE_TRL; res.param_index = pcnt;
          end
        end
        default: begin
          ns = ST_ERR;
        end
      endcase

      if (ns == ST_ERR) begin
        res.byte_role   = ROLE_BAD;
        res.param_index = '0;
        res.field_start = 1'b0;
      end

      state_nxt = ns;
      pcnt_nxt  = pc;
      if (word.line_end) begin
        res.verdict_valid = 1'b1;
        res.accepted      = (ns == ST_DONE);
        state_nxt         = ST_START;
        pcnt_nxt          = '0;
      end
    end
  end

endmodule

>>> hdl/irc_message_line_parser.sv
// Top level of the IRC message line parser: input register, grammar step, result register.
// Depends on irc_pkg and irc_step.
//
//   channel   direction   handshake            payload
//   in_       into block  in_valid / in_stall   in_word  (in_word_t)
//   out_      out of it   out_valid / out_stall out_word (out_word_t)
//
// One byte is taken per clock while in_stall is low; each result is offered registered.
// The grammar state update sits between the input register and the result register.
// Reset clears the grammar state, the parameter count, the skip flag and both valid flags.
// A stall on the result side holds the result register. Once the input register also holds
// a word, in_stall follows out_stall in the same cycle, so no word is lost.
module irc_message_line_parser import irc_pkg::*; #(
  parameter int MAX_PARAMS = 15
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic       in_vld_r;
  in_word_t   in_word_r;
  logic       out_vld_r;
  out_word_t  out_word_r;
  logic [3:0] state_r;
  logic [3:0] pcnt_r;
  logic       skip_r;

  out_word_t  res;
  logic [3:0] state_nxt;
  logic [3:0] pcnt_nxt;
  logic       skip_nxt;
  logic       out_adv;
  logic       in_adv;
  logic       step_go;

  irc_step #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_step (
    .word      (in_word_r),
    .state     (state_r),
    .pcnt      (pcnt_r),
    .skip      (skip_r),
    .res       (res),
    .state_nxt (state_nxt),
    .pcnt_nxt  (pcnt_nxt),
    .skip_nxt  (skip_nxt)
  );

  assign out_adv  = !out_vld_r || !out_stall;
  assign in_adv   = !in_vld_r || out_adv;
  assign step_go  = in_vld_r && out_adv;
  assign in_stall = !in_adv;

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= ST_START;
      pcnt_r    <= '0;
      skip_r    <= 1'b0;
    end else begin
      if (in_adv) begin
        in_vld_r <= in_valid;
      end
      if (out_adv) begin
        out_vld_r <= in_vld_r;
      end
      if (step_go) begin
        state_r <= state_nxt;
        pcnt_r  <= pcnt_nxt;
        skip_r  <= skip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      in_word_r <= in_word;
    end
    if (step_go) begin
      out_word_r <= res;
    end
  end

endmodule

>>> hdl/irc_checker.sv
// Port-level checks for the IRC message line parser, bound to the top level.
// Depends on irc_pkg and irc_message_line_parser.
module irc_checker import irc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // An accepted message is only ever reported together with a verdict.
  a_acc_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.accepted |-> out_word.verdict_valid)
    else $error("accepted without verdict");

  // An accepted line ends on its CR or on a NUL, which is a separator word.
  a_acc_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.accepted |->
      (out_word.byte_role == ROLE_CR) || (out_word.byte_role == ROLE_SEP))
    else $error("accepted on an unexpected role");

  // A parameter index belongs to parameter bytes only.
  a_pidx_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.param_index != 4'd0) |->
      (out_word.byte_role == ROLE_MID) || (out_word.byte_role == ROLE_TRL))
    else $error("parameter index on a non-parameter word");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // The input side only stalls while the result side is stalled.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall)
    else $error("input stalled without a result stall");

endmodule

bind irc_message_line_parser irc_checker u_irc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for irc_message_line_parser: random and directed message lines,
// a built-in grammar predictor, random idling on the input and back-pressure on the results.
// Depends on irc_pkg and the irc_message_line_parser RTL.
module testbench;
  import irc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PARAM_CAP    = 15;
  localparam int ITEMS        = 700;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 48;

  typedef struct {
    in_word_t word;
    bit       drain_first;
  } pending_word_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  pending_word_t word_q[$];
  out_word_t     expected_q[$];
  logic [7:0]    line_buf[$];

  int unsigned cyc = 0;
  int unsigned mismatches = 0;
  int unsigned total_words = 0;
  int unsigned words_taken = 0;
  bit          in_took = 1'b0;

  // Predictor copy of the parser state.
  logic [3:0] gstate = ST_START;
  logic [3:0] pcount = '0;
  logic       skip   = 1'b0;

  irc_message_line_parser #(.MAX_PARAMS(PARAM_CAP)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit is_plain(logic [7:0] c);
    return c != CH_NUL && c != CH_LF && c != CH_CR && c != CH_SPACE && c != CH_COLON;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic void restart_line();
    gstate = ST_START;
    pcount = '0;
    skip   = 1'b0;
  endfunction

  // Appends one byte to the line under construction.
  function automatic void append_byte(logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endfunction

  // Classifies one byte and advances the predicted grammar state.
  function automatic out_word_t parse_byte(in_word_t w);
    out_word_t  r;
    logic [7:0] c;
    logic [3:0] nxt;
    logic [3:0] pc;
    r   = '0;
    c   = w.data_byte;
    nxt = ST_ERR;
    pc  = pcount;
    if (skip) begin
      if (w.line_end) restart_line();
    end else if (c == CH_NUL) begin
      r.verdict_valid = 1'b1;
      r.accepted = (gstate == ST_DONE);
      if (w.line_end) restart_line();
      else skip = 1'b1;
    end else begin
      r.byte_role = ROLE_SEP;
      case (gstate)
        ST_START: begin
          if (c == CH_COLON) nxt = ST_PFX_FIRST;
          else if (is_letter(c)) begin
            nxt = ST_CMD_ALPHA; r.byte_role = ROLE_CMD; r.field_start = 1'b1;
          end else if (is_digit(c)) begin
            nxt = ST_CMD_D1; r.byte_role = ROLE_CMD; r.field_start = 1'b1;
          end
        end
        ST_PFX_FIRST: begin
          if (is_plain(c)) begin
            nxt = ST_PFX; r.byte_role = ROLE_PFX; r.field_start = 1'b1;
          end
        end
        ST_PFX: begin
          if (is_plain(c)) begin
            nxt = ST_PFX; r.byte_role = ROLE_PFX;
          end else if (c == CH_SPACE) nxt = ST_PFX_SP;
        end
        ST_PFX_SP: begin
          if (c == CH_SPACE) nxt = ST_PFX_SP;
          else if (is_letter(c)) begin
            nxt = ST_CMD_ALPHA; r.byte_role = ROLE_CMD; r.field_start = 1'b1;
          end else if (is_digit(c)) begin
            nxt = ST_CMD_D1; r.byte_role = ROLE_CMD; r.field_start = 1'b1;
          end
        end
        ST_CMD_ALPHA: begin
          if (is_letter(c)) begin
            nxt = ST_CMD_ALPHA; r.byte_role = ROLE_CMD;
          end else if (c == CH_SPACE) nxt = ST_PAR_SP;
        end
        ST_CMD_D1: begin
          if (is_digit(c)) begin
            nxt = ST_CMD_D2; r.byte_role = ROLE_CMD;
          end
        end
        ST_CMD_D2: begin
          if (is_digit(c)) begin
            nxt = ST_CMD_D3; r.byte_role = ROLE_CMD;
          end
        end
        ST_CMD_D3: begin
          if (c == CH_SPACE) nxt = ST_PAR_SP;
        end
        ST_PAR_SP: begin
          if (c == CH_SPACE) nxt = ST_PAR_SP;
          else if (c == CH_COLON) nxt = ST_TRAIL_1ST;
          else if (c == CH_CR) begin
            nxt = ST_DONE; r.byte_role = ROLE_CR;
          end else if (is_plain(c)) begin
            nxt = ST_MID; r.byte_role = ROLE_MID; r.param_index = pc; r.field_start = 1'b1;
          end
        end
        ST_TRAIL_1ST: begin
          if (c != CH_LF && c != CH_CR) begin
            nxt = ST_TRAIL; r.byte_role = ROLE_TRL; r.param_index = pc; r.field_start = 1'b1;
          end
        end
        ST_MID: begin
          if (is_plain(c) || c == CH_COLON) begin
            nxt = ST_MID; r.byte_role = ROLE_MID; r.param_index = pc;
          end else if (c == CH_SPACE) begin
            nxt = ST_PAR_SP;
            if (pc < PARAM_CAP) pc = pc + 4'd1;
          end
        end
        ST_TRAIL: begin
          if (c == CH_CR) begin
            nxt = ST_DONE; r.byte_role = ROLE_CR;
          end else if (c != CH_LF) begin
            nxt = ST_TRAIL; r.byte_role = ROLE_TRL; r.param_index = pc;
          end
        end
        default: ;
      endcase
      if (nxt == ST_ERR) begin
        r.byte_role = ROLE_BAD; r.param_index = '0; r.field_start = 1'b0;
      end
      gstate = nxt;
      pcount = pc;
      if (w.line_end) begin
        r.verdict_valid = 1'b1;
        r.accepted = (nxt == ST_DONE);
        restart_line();
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (!is_plain(c)) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == CH_CR || c == CH_LF) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic void add_spaces();
    int n;
    n = $urandom_range(1, 2);
    repeat (n) append_byte(CH_SPACE);
  endfunction

  // Builds a grammatical line with random content into line_buf.
  function automatic void make_good_line();
    int n;
    int mids;
    line_buf.delete();
    if ($urandom_range(0, 1)) begin
      append_byte(CH_COLON);
      n = $urandom_range(1, 6);
      repeat (n) append_byte(plain_byte());
      add_spaces();
    end
    if ($urandom_range(0, 1)) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 1)) append_byte(8'h41 + 8'($urandom_range(0, 25)));
        else append_byte(8'h61 + 8'($urandom_range(0, 25)));
      end
    end else begin
      repeat (3) append_byte(8'h30 + 8'($urandom_range(0, 9)));
    end
    add_spaces();
    // Now and then enough parameters to push the index into saturation.
    mids = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 3);
    repeat (mids) begin
      append_byte(plain_byte());
      n = (mids > 10) ? 0 : $urandom_range(0, 4);
      repeat (n) append_byte($urandom_range(0, 3) == 0 ? CH_COLON : plain_byte());
      add_spaces();
    end
    if ($urandom_range(0, 1)) begin
      append_byte(CH_COLON);
      n = $urandom_range(1, 8);
      repeat (n) append_byte(text_byte());
    end
    append_byte(CH_CR);
  endfunction

  function automatic void queue_line(bit drain_first);
    pending_word_t p;
    foreach (line_buf[i]) begin
      p.word.data_byte = line_buf[i];
      p.word.line_end  = (i == line_buf.size() - 1);
      p.drain_first    = drain_first && (i == 0);
      word_q.insert(word_q.size(), p);
      total_words++;
    end
  endfunction

  // Sender: bursts of words separated by random gaps.
  always @(negedge clk) begin : drive_words
    pending_word_t cur;
    bit            go;
    int            gap_left;
    int            burst_left;
    if (rst_n && !(in_valid && !in_took)) begin
      go = 1'b0;
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (word_q.size() > 0 && (!word_q[0].drain_first || expected_q.size() == 0)) begin
        cur = word_q.pop_front();
        go  = 1'b1;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
        end
      end
      in_valid <= go;
      if (go) in_word <= cur.word;
    end
  end

  // Receiver: stall density changes from one stretch to the next, plus one long hold-off.
  always @(negedge clk) begin : stall_results
    bit stall;
    int hold_left;
    int seg_left;
    int stall_pct;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      stall = 1'b1;
    end else if (cyc == HOLD_AT) begin
      hold_left = HOLD_LEN;
      stall = 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 60);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left = seg_left - 1;
      stall = ($urandom_range(0, 99) < stall_pct);
    end
    out_stall <= stall;
  end

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  // Records accepted input words and checks each accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    out_word_t want;
    cyc++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, got %p", $time, out_word);
      end else begin
        want = expected_q.pop_front();
        check_field("byte_role", 8'(want.byte_role), 8'(out_word.byte_role));
        check_field("param_index", 8'(want.param_index), 8'(out_word.param_index));
        check_field("field_start", 8'(want.field_start), 8'(out_word.field_start));
        check_field("verdict_valid", 8'(want.verdict_valid), 8'(out_word.verdict_valid));
        check_field("accepted", 8'(want.accepted), 8'(out_word.accepted));
      end
    end
    in_took = rst_n && in_valid && !in_stall;
    if (in_took) begin
      expected_q.insert(expected_q.size(), parse_byte(in_word));
      words_taken++;
    end
    if (cyc >= LIMIT_CYCLES) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : run
    int kind;
    int idx;
    int n;

    // Prefix after a leading colon, letter command, one middle and a trailing part.
    line_buf = {CH_COLON, 8'h70, CH_SPACE, 8'h41, CH_SPACE, 8'h62, CH_SPACE, CH_COLON,
                8'hFF, CH_CR};
    queue_line(1'b0);
    // Numeric command with no parameters.
    line_buf = {8'h31, 8'h32, 8'h33, CH_SPACE, CH_CR};
    queue_line(1'b0);
    // Error on the first byte, a NUL that is not last, then an ignored byte.
    line_buf = {CH_CR, CH_NUL, 8'h80};
    queue_line(1'b0);
    // A lone NUL as the whole line.
    line_buf = {CH_NUL};
    queue_line(1'b0);
    // A byte after the final CR, with a line feed thrown in.
    line_buf = {8'h7A, CH_SPACE, CH_CR, CH_LF};
    queue_line(1'b1);
    // CR followed by NUL as the last byte is accepted.
    line_buf = {8'h5A, CH_SPACE, CH_CR, CH_NUL};
    queue_line(1'b0);

    while (total_words < ITEMS) begin
      kind = $urandom_range(0, 99);
      make_good_line();
      if (kind >= 65 && kind < 75) begin
        idx = $urandom_range(0, line_buf.size() - 1);
        line_buf[idx] = 8'($urandom_range(0, 255));
      end else if (kind >= 75 && kind < 82) begin
        line_buf.delete(line_buf.size() - 1);
      end else if (kind >= 82 && kind < 88) begin
        append_byte(8'($urandom_range(0, 255)));
      end else if (kind >= 88 && kind < 94) begin
        idx = $urandom_range(0, line_buf.size());
        if (idx == line_buf.size()) append_byte(CH_NUL);
        else line_buf[idx] = CH_NUL;
      end else if (kind >= 94) begin
        line_buf.delete();
        n = $urandom_range(1, 8);
        repeat (n) append_byte(8'($urandom_range(0, 255)));
      end
      queue_line($urandom_range(0, 19) == 0);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_taken < total_words) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
